@@ design/i2crm_pkg.sv @@
package i2crm_pkg;

  localparam int CFG_INDEX_W = 2;

  localparam logic [7:0] RESET_SLAVE_ADDRESS  = 8'd162;
  localparam logic [7:0] RESET_ACK_POLL_LIMIT = 8'd250;

  // bit count at which a byte is complete
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SLAVE_ADDRESS  = 2'd0,
    CFG_ACK_POLL_LIMIT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_IDLE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_START   = 4'd1,
    ST_ADDRW   = 4'd2,
    ST_REG     = 4'd3,
    ST_DATA    = 4'd4,
    ST_RESTART = 4'd5,
    ST_ADDRR   = 4'd6,
    ST_READ    = 4'd7,
    ST_STOP    = 4'd8
  } stage_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_result;
    logic       ack_error;
  } out_word_t;

  typedef struct packed {
    logic [7:0] slave_address;
    logic [7:0] ack_poll_limit;
  } cfg_regs_t;

endpackage

@@ design/i2crm_if.sv @@
interface i2crm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] reg_address;
  logic [7:0] write_data;
  logic       sda_in;

  modport source (output valid, cmd, reg_address, write_data, sda_in, input ready);
  modport sink   (input valid, cmd, reg_address, write_data, sda_in, output ready);
endinterface

interface i2crm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_result;
  logic       ack_error;

  modport source (output valid, scl_level, sda_release, busy_res, done_res, read_result,
                  ack_error, input ready);
  modport sink   (input valid, scl_level, sda_release, busy_res, done_res, read_result,
                  ack_error, output ready);
endinterface

interface i2crm_cfg_if;
  import i2crm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [7:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/i2crm_core.sv @@
module i2crm_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  i2crm_pkg::in_word_t  in_word,
  input  i2crm_pkg::cfg_regs_t cfg,
  output i2crm_pkg::out_word_t result
);
  import i2crm_pkg::*;

  stage_t     stage_r, stage_nxt, stage_cur;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] bit_count_r, bit_count_nxt, bit_count_inc;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic [7:0] lat_reg_r, lat_reg_nxt;
  logic [7:0] lat_data_r, lat_data_nxt;
  logic       read_mode_r, read_mode_nxt;
  logic [7:0] rx_byte_r, rx_byte_nxt;
  logic       error_r, error_nxt;
  logic       is_cmd, scl, sda;
  logic [7:0] shift_in;

  assign bit_count_inc = bit_count_r + 4'd1;
  assign shift_in      = {shift_r[6:0], in_word.sda_in};
  assign is_cmd        = (in_word.cmd == CMD_WRITE) || (in_word.cmd == CMD_READ);

  always_comb begin
    stage_cur = (stage_r > ST_STOP) ? ST_IDLE : stage_r;
  end

  // bus levels of the current phase
  always_comb begin
    scl = 1'b1;
    sda = 1'b1;
    unique case (stage_cur)
      ST_START, ST_RESTART: begin
        scl = (phase_r == 2'd1) || (phase_r == 2'd2);
        sda = (phase_r <= 2'd1);
      end
      ST_ADDRW, ST_REG, ST_DATA, ST_ADDRR: begin
        scl = phase_r[0];
        sda = (phase_r < 2'd2) ? shift_r[7] : 1'b1;
      end
      ST_READ: begin
        scl = phase_r[0];
      end
      ST_STOP: begin
        scl = (phase_r != 2'd0);
        sda = (phase_r >= 2'd2);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.scl_level   = scl;
    result.sda_release = sda;
    result.busy_res    = (stage_cur != ST_IDLE);
    result.done_res    = (stage_cur == ST_STOP) && (phase_r >= 2'd2);
    result.read_result = rx_byte_r;
    result.ack_error   = error_r;
  end

  always_comb begin
    stage_nxt     = stage_cur;
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    poll_nxt      = poll_r;
    lat_reg_nxt   = lat_reg_r;
    lat_data_nxt  = lat_data_r;
    read_mode_nxt = read_mode_r;
    rx_byte_nxt   = rx_byte_r;
    error_nxt     = error_r;
    if (stage_r > ST_STOP) begin
      phase_nxt = 2'd0;
    end
    unique case (stage_cur)
      ST_IDLE: begin
        if (is_cmd) begin
          lat_reg_nxt   = in_word.reg_address;
          lat_data_nxt  = in_word.write_data;
          read_mode_nxt = (in_word.cmd == CMD_READ);
          error_nxt     = 1'b0;
          bit_count_nxt = 4'd0;
          poll_nxt      = 8'd0;
          stage_nxt     = ST_START;
          phase_nxt     = 2'd2;
        end
      end
      ST_START, ST_RESTART: begin
        if (phase_r != 2'd3) begin
          phase_nxt = phase_r + 2'd1;
        end else begin
          bit_count_nxt = 4'd0;
          phase_nxt     = 2'd0;
          if (stage_cur == ST_START) begin
            shift_nxt = {cfg.slave_address[7:1], 1'b0};
            stage_nxt = ST_ADDRW;
          end else begin
            shift_nxt = {cfg.slave_address[7:1], 1'b1};
            stage_nxt = ST_ADDRR;
          end
        end
      end
      ST_ADDRW, ST_REG, ST_DATA, ST_ADDRR: begin
        case (phase_r)
          2'd0: phase_nxt = 2'd1;
          2'd1: begin
            shift_nxt     = {shift_r[6:0], 1'b0};
            bit_count_nxt = bit_count_inc;
            phase_nxt     = (bit_count_inc >= BYTE_BITS) ? 2'd2 : 2'd0;
          end
          2'd2: begin
            poll_nxt  = 8'd0;
            phase_nxt = 2'd3;
          end
          default: begin
            if (!in_word.sda_in) begin
              // slave acknowledged: advance to the next stage of the transaction
              bit_count_nxt = 4'd0;
              phase_nxt     = 2'd0;
              if (stage_cur == ST_ADDRW) begin
                shift_nxt = lat_reg_r;
                stage_nxt = ST_REG;
              end else if (stage_cur == ST_REG && read_mode_r) begin
                stage_nxt = ST_RESTART;
              end else if (stage_cur == ST_REG) begin
                shift_nxt = lat_data_r;
                stage_nxt = ST_DATA;
              end else if (stage_cur == ST_ADDRR) begin
                shift_nxt = 8'd0;
                stage_nxt = ST_READ;
              end else begin
                stage_nxt = ST_STOP;
              end
            end else if (poll_r >= cfg.ack_poll_limit) begin
              error_nxt = 1'b1;
              stage_nxt = ST_STOP;
              phase_nxt = 2'd0;
            end else begin
              poll_nxt = poll_r + 8'd1;
            end
          end
        endcase
      end
      ST_READ: begin
        case (phase_r)
          2'd0: phase_nxt = 2'd1;
          2'd1: begin
            shift_nxt     = shift_in;
            bit_count_nxt = bit_count_inc;
            if (bit_count_inc >= BYTE_BITS) begin
              rx_byte_nxt = shift_in;
              phase_nxt   = 2'd2;
            end else begin
              phase_nxt = 2'd0;
            end
          end
          2'd2: phase_nxt = 2'd3;
          default: begin
            stage_nxt = ST_STOP;
            phase_nxt = 2'd0;
          end
        endcase
      end
      default: begin
        // stop condition
        if (phase_r < 2'd2) begin
          phase_nxt = phase_r + 2'd1;
        end else begin
          stage_nxt = ST_IDLE;
          phase_nxt = 2'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_IDLE;
      phase_r     <= 2'd0;
      bit_count_r <= 4'd0;
      shift_r     <= 8'd0;
      poll_r      <= 8'd0;
      lat_reg_r   <= 8'd0;
      lat_data_r  <= 8'd0;
      read_mode_r <= 1'b0;
      rx_byte_r   <= 8'd0;
      error_r     <= 1'b0;
    end else if (accept) begin
      stage_r     <= stage_nxt;
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      poll_r      <= poll_nxt;
      lat_reg_r   <= lat_reg_nxt;
      lat_data_r  <= lat_data_nxt;
      read_mode_r <= read_mode_nxt;
      rx_byte_r   <= rx_byte_nxt;
      error_r     <= error_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && stage_r == ST_IDLE && is_cmd |=> stage_r == ST_START && phase_r == 2'd2)
    else $error("command in idle did not open a start condition");

  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_count_r <= BYTE_BITS)
    else $error("bit count ran past one byte");

  a_rx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(rx_byte_r) && $stable(stage_r))
    else $error("state moved without an accepted word");

  a_stage_legal: assert property (@(posedge clk) disable iff (!rst_n)
    stage_r <= ST_STOP)
    else $error("sequencer reached an unused stage");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    accept && result.done_res |=> stage_r == ST_IDLE)
    else $error("stop completed but sequencer not idle");
`endif

endmodule

@@ design/i2c_register_access_master.sv @@
// Single-register I2C master. Each input word is one bus phase tick and gives
// exactly one result word with the SCL/SDA levels of that tick, so one word is
// taken per clock whenever the result side keeps up; the result register frees
// as it is taken, and the only stall is a full result register facing a low
// out ready. cmd 1 (write) or 2 (read) in an idle tick starts a transaction on
// the next tick; the command tick itself still reports idle. busy_res covers
// the transaction, done_res marks the single tick in which the stop completes,
// ack_error reports an acknowledge timeout (ack_poll_limit + 1 high poll ticks)
// and clears on the next command. Configuration (index 0 slave address, 1 poll
// limit) should be written only while idle; other indexes are ignored.
module i2c_register_access_master (
  input logic         clk,
  input logic         rst_n,
  i2crm_in_if.sink    in_if,
  i2crm_out_if.source out_if,
  i2crm_cfg_if.sink   cfg_if
);
  import i2crm_pkg::*;

  cfg_regs_t cfg_r;
  in_word_t  in_word;
  out_word_t core_res, out_r;
  logic      out_valid_r;
  logic      accept;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address  <= RESET_SLAVE_ADDRESS;
      cfg_r.ack_poll_limit <= RESET_ACK_POLL_LIMIT;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_SLAVE_ADDRESS:  cfg_r.slave_address  <= cfg_if.data;
        CFG_ACK_POLL_LIMIT: cfg_r.ack_poll_limit <= cfg_if.data;
        default: begin
        end
      endcase
    end
  end

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    in_word.cmd         = in_if.cmd;
    in_word.reg_address = in_if.reg_address;
    in_word.write_data  = in_if.write_data;
    in_word.sda_in      = in_if.sda_in;
  end

  i2crm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_word),
    .cfg     (cfg_r),
    .result  (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= core_res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.scl_level   = out_r.scl_level;
  assign out_if.sda_release = out_r.sda_release;
  assign out_if.busy_res    = out_r.busy_res;
  assign out_if.done_res    = out_r.done_res;
  assign out_if.read_result = out_r.read_result;
  assign out_if.ack_error   = out_r.ack_error;

endmodule
